@@ sv/fsng_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsng_pkg: shared types and constants of the short name generator
// Character codes, name geometry and the code unit classifier used by the
// front part, and the name word that travels through the queue.
// ----------------------------------------------------------------------------
package fsng_pkg;

	localparam int unsigned SHORT_LEN = 11;
	localparam int unsigned BASE_LEN  = 8;
	localparam int unsigned EXT_LEN   = 3;
	localparam int unsigned TILDE_POS = 6;
	localparam int unsigned UNIT_W    = 9;
	localparam int unsigned IDX_W     = 4;

	localparam logic [UNIT_W-1:0] MAX_NAME_UNITS = 9'd255;
	localparam logic [IDX_W-1:0]  LAST_IDX       = 4'(SHORT_LEN - 1);

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0]  CH_SPACE = 8'h20;
	localparam logic [7:0]  CH_UNDER = 8'h5F;
	localparam logic [7:0]  CH_TILDE = 8'h7E;
	localparam logic [7:0]  CH_ONE   = 8'h31;
	localparam logic [7:0]  CASE_GAP = 8'h20;
	localparam logic [15:0] CU_DOT   = 16'h002E;
	localparam logic [15:0] CU_UP_A  = 16'h0041;
	localparam logic [15:0] CU_UP_Z  = 16'h005A;
	localparam logic [15:0] CU_LO_A  = 16'h0061;
	localparam logic [15:0] CU_LO_Z  = 16'h007A;
	localparam logic [15:0] CU_DIG_0 = 16'h0030;
	localparam logic [15:0] CU_DIG_9 = 16'h0039;

	// Byte i of the short name sits at element i.
	typedef logic [SHORT_LEN-1:0][7:0] name_t;

	typedef struct packed {
		logic       keep;
		logic [7:0] ch;
	} mapped_t;

	typedef enum logic {
		BK_IDLE,
		BK_EMIT
	} back_state_t;

	// Letters and digits give an upper case character; anything else gives
	// an underscore and is not kept for the extension.
	function automatic mapped_t map_unit(input logic [15:0] u);
		mapped_t m;
		m.keep = 1'b1;
		m.ch   = u[7:0];
		if ((u >= CU_UP_A && u <= CU_UP_Z) || (u >= CU_DIG_0 && u <= CU_DIG_9)) begin
			m.ch = u[7:0];
		end else if (u >= CU_LO_A && u <= CU_LO_Z) begin
			m.ch = u[7:0] - CASE_GAP;
		end else begin
			m.keep = 1'b0;
			m.ch   = CH_UNDER;
		end
		return m;
	endfunction

endpackage

@@ sv/fsng_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsng_front: code unit intake
// Classifies each code unit, keeps base and extension characters, and on the
// last unit builds the padded 8.3 name word and clears itself.
// ----------------------------------------------------------------------------
module fsng_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [15:0]           code_unit,
	input  logic                  last_unit,
	output logic                  name_push,
	output fsng_pkg::name_t       name_word
);

	logic [fsng_pkg::BASE_LEN-1:0][7:0] base_q, base_d;
	logic [fsng_pkg::EXT_LEN-1:0][7:0]  ext_q, ext_d;
	logic [1:0]                         ext_cnt_q, ext_cnt_d;
	logic [fsng_pkg::UNIT_W-1:0]        unit_cnt_q, unit_cnt_d;
	logic [fsng_pkg::UNIT_W-1:0]        dot_pos_q, dot_pos_d;
	logic [fsng_pkg::UNIT_W-1:0]        base_len;
	fsng_pkg::mapped_t                  mapped;

	always_comb begin
		base_d     = base_q;
		ext_d      = ext_q;
		ext_cnt_d  = ext_cnt_q;
		unit_cnt_d = unit_cnt_q;
		dot_pos_d  = dot_pos_q;
		mapped     = fsng_pkg::map_unit(code_unit);
		if (unit_cnt_q < fsng_pkg::MAX_NAME_UNITS) begin
			if (unit_cnt_q < fsng_pkg::UNIT_W'(fsng_pkg::BASE_LEN)) begin
				base_d[unit_cnt_q[2:0]] = mapped.ch;
			end
			// A dot at the very first position is part of the base.
			if (code_unit == fsng_pkg::CU_DOT && unit_cnt_q != '0) begin
				dot_pos_d = unit_cnt_q;
				ext_cnt_d = '0;
				ext_d     = {fsng_pkg::EXT_LEN{fsng_pkg::CH_SPACE}};
			end else if (dot_pos_q != '0 && ext_cnt_q < 2'(fsng_pkg::EXT_LEN)
					&& mapped.keep) begin
				ext_d[ext_cnt_q] = mapped.ch;
				ext_cnt_d        = ext_cnt_q + 2'd1;
			end
			unit_cnt_d = unit_cnt_q + 1'b1;
		end
	end

	always_comb begin
		base_len = (dot_pos_d != '0) ? dot_pos_d : unit_cnt_d;
		for (int i = 0; i < fsng_pkg::BASE_LEN; i++) begin
			name_word[i] = (fsng_pkg::UNIT_W'(i) < base_len) ? base_d[i] : fsng_pkg::CH_SPACE;
		end
		if (base_len > fsng_pkg::UNIT_W'(fsng_pkg::BASE_LEN)) begin
			name_word[fsng_pkg::TILDE_POS]     = fsng_pkg::CH_TILDE;
			name_word[fsng_pkg::TILDE_POS + 1] = fsng_pkg::CH_ONE;
		end
		for (int j = 0; j < fsng_pkg::EXT_LEN; j++) begin
			name_word[fsng_pkg::BASE_LEN + j] = ext_d[j];
		end
	end

	assign name_push = accept & last_unit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= {fsng_pkg::BASE_LEN{fsng_pkg::CH_SPACE}};
			ext_q      <= {fsng_pkg::EXT_LEN{fsng_pkg::CH_SPACE}};
			ext_cnt_q  <= '0;
			unit_cnt_q <= '0;
			dot_pos_q  <= '0;
		end else if (accept) begin
			if (last_unit) begin
				base_q     <= {fsng_pkg::BASE_LEN{fsng_pkg::CH_SPACE}};
				ext_q      <= {fsng_pkg::EXT_LEN{fsng_pkg::CH_SPACE}};
				ext_cnt_q  <= '0;
				unit_cnt_q <= '0;
				dot_pos_q  <= '0;
			end else begin
				base_q     <= base_d;
				ext_q      <= ext_d;
				ext_cnt_q  <= ext_cnt_d;
				unit_cnt_q <= unit_cnt_d;
				dot_pos_q  <= dot_pos_d;
			end
		end
	end

endmodule

@@ sv/fsng_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsng_queue: name word queue
// A small first-in first-out store of finished names between intake and
// emission.
// ----------------------------------------------------------------------------
module fsng_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fsng_pkg::name_t push_word,
	input  logic            pop,
	output fsng_pkg::name_t pop_word,
	output logic            full,
	output logic            empty
);

	fsng_pkg::name_t             slot_q [fsng_pkg::QUEUE_DEPTH];
	logic [fsng_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [fsng_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [fsng_pkg::QCNT_W-1:0] cnt_q;
	logic                        do_push;
	logic                        do_pop;

	assign full     = (cnt_q == fsng_pkg::QCNT_W'(fsng_pkg::QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push & ~full;
	assign do_pop   = pop & ~empty;
	assign pop_word = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= fsng_pkg::QCNT_W'(fsng_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("name pushed into a full queue");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == fsng_pkg::QCNT_W'(1) && do_pop && !do_push) |=> empty)
		else $error("queue not empty after last word left");

endmodule

@@ sv/fsng_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsng_back: byte emitter
// Takes one name word from the queue and sends its eleven bytes out one at a
// time, folding each into the rotate-add checksum.
// ----------------------------------------------------------------------------
module fsng_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  fsng_pkg::name_t            q_word,
	output logic                       q_pop,
	input  logic                       pop,
	output logic                       empty,
	output logic [fsng_pkg::IDX_W-1:0] byte_index,
	output logic [7:0]                 name_byte,
	output logic [7:0]                 name_checksum,
	output logic                       final_byte
);

	fsng_pkg::back_state_t        state_q, state_d;
	fsng_pkg::name_t              name_q;
	logic [fsng_pkg::IDX_W-1:0]   idx_q;
	logic [7:0]                   sum_q;
	logic [7:0]                   sum_next;
	logic [7:0]                   cur_byte;
	logic                         out_valid_q;
	logic                         advance;
	logic                         emit;
	logic                         at_last;

	assign advance  = ~out_valid_q | pop;
	assign at_last  = (idx_q == fsng_pkg::LAST_IDX);
	assign cur_byte = name_q[idx_q];
	assign sum_next = {sum_q[0], sum_q[7:1]} + cur_byte;

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		emit    = 1'b0;
		case (state_q)
			fsng_pkg::BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = fsng_pkg::BK_EMIT;
				end
			end
			fsng_pkg::BK_EMIT: begin
				if (advance) begin
					emit = 1'b1;
					if (at_last) begin
						state_d = fsng_pkg::BK_IDLE;
					end
				end
			end
			default: begin
				state_d = fsng_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsng_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			sum_q       <= '0;
		end else begin
			if (q_pop) begin
				idx_q <= '0;
				sum_q <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
				sum_q <= sum_next;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			name_q <= q_word;
		end
		if (emit) begin
			byte_index    <= idx_q;
			name_byte     <= cur_byte;
			name_checksum <= at_last ? sum_next : 8'h00;
			final_byte    <= at_last;
		end
	end

	assign empty = ~out_valid_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fsng_pkg::BK_EMIT |-> idx_q <= fsng_pkg::LAST_IDX)
		else $error("byte counter ran past the name");

	a_final_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (final_byte == (byte_index == fsng_pkg::LAST_IDX)))
		else $error("final flag on the wrong byte");

	a_sum_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !final_byte) |-> name_checksum == 8'h00)
		else $error("checksum shown before the final byte");

endmodule

@@ sv/fat_short_name_generator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_short_name_generator_unit: 8.3 short name and LFN checksum generator
// Turns a stream of UTF-16 code units into the eleven bytes of a FAT short
// name, with the long name entry checksum on the last byte.
// ----------------------------------------------------------------------------
// The block takes one code unit per cycle while full is low. Letters and
// digits are kept in upper case, other units become an underscore in the
// base and are dropped from the extension; the latest dot after the first
// unit starts the extension. When the unit flagged as last is taken, the
// finished name word enters a two-entry queue and intake starts over at
// once on the next name. The emitter then loads a word into its name
// register and sends the eleven bytes, index 0 to 10, one per cycle while
// pop stays high, through an output register. The checksum is built
// serially, one byte per cycle while pop stays high, and is given on the
// byte that has final_byte set; it reads zero on the other ten. Base names
// longer than eight units end in "~1". Units beyond the 255th are ignored,
// but a last flag on them still ends the name. full rises only while two
// finished names are waiting behind the emitter.
// ----------------------------------------------------------------------------
module fat_short_name_generator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] code_unit,
	input  logic        last_unit,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  byte_index,
	output logic [7:0]  name_byte,
	output logic [7:0]  name_checksum,
	output logic        final_byte
);

	logic            accept;
	logic            name_push;
	fsng_pkg::name_t name_word;
	fsng_pkg::name_t q_word;
	logic            q_pop;
	logic            q_empty;
	logic            q_full;

	// Intake is stalled only by the queue; a word that does not end a name
	// could always be taken, but holding all units keeps the rule simple.
	assign full   = q_full;
	assign accept = push & ~q_full;

	fsng_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.code_unit (code_unit),
		.last_unit (last_unit),
		.name_push (name_push),
		.name_word (name_word)
	);

	fsng_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (name_push),
		.push_word (name_word),
		.pop       (q_pop),
		.pop_word  (q_word),
		.full      (q_full),
		.empty     (q_empty)
	);

	fsng_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_word        (q_word),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.byte_index    (byte_index),
		.name_byte     (name_byte),
		.name_checksum (name_checksum),
		.final_byte    (final_byte)
	);

endmodule
